[rtl/core/vrtp_pkg.sv]
// ----------------------------------------------------------------------------
// vrtp_pkg
// Shared constants, types and helper functions of the vertex rotate,
// translate and project unit.
// ----------------------------------------------------------------------------
package vrtp_pkg;

   // Number formats
   localparam int ANGLE_BITS    = 16;
   localparam int FRACTION_BITS = 8;
   localparam int CENTER_X      = 160;
   localparam int CENTER_Y      = 100;

   localparam int FIELD_W  = 24;               // port coordinate width
   localparam int ANGLE_W  = 16;               // angle register width
   localparam int DIST_W   = 16;               // view distance width
   localparam int TRIG_W   = 16;               // Q14 sine/cosine, signed
   localparam int TRIG_FRAC = 14;
   localparam int ROT_ROUND = 1 << (TRIG_FRAC - 1);

   // quarter turn, added to an angle to get its cosine
   localparam logic [ANGLE_BITS-1:0] QUARTER_TURN = ANGLE_BITS'(1 << (ANGLE_BITS - 2));

   // Quarter-wave polynomial, Q16
   localparam int PHASE_W   = 17;
   localparam int PHASE_ONE = 65536;
   localparam int POLY_A    = 102944;
   localparam int POLY_B    = 42048;
   localparam int POLY_C    = 4640;
   localparam int SINE_LATENCY = 5;
   localparam int SETTLE_W  = $clog2(SINE_LATENCY + 1);

   // Internal datapath widths
   localparam int COORD_W = 32;                           // rotated coordinates
   localparam int PROD_W  = COORD_W + TRIG_W;             // rotation products
   localparam int NUM_W   = COORD_W + DIST_W + 1;         // coord * distance
   localparam int N_W     = NUM_W + FRACTION_BITS + 2;    // dividend
   localparam int D_W     = COORD_W + 1;                  // divisor 2|z|
   localparam int QUO_W   = FIELD_W + 1;                  // quotient bits kept

   localparam int FRONT_STAGES = 10;
   localparam int PIPE_DEPTH   = FRONT_STAGES + QUO_W;

   localparam logic signed [FIELD_W-1:0] FIELD_MAX = {1'b0, {(FIELD_W-1){1'b1}}};
   localparam logic signed [FIELD_W-1:0] FIELD_MIN = {1'b1, {(FIELD_W-1){1'b0}}};

   // Register map
   typedef enum logic [2:0] {
      REG_ANGLE_X,
      REG_ANGLE_Y,
      REG_ANGLE_Z,
      REG_SHIFT_X,
      REG_SHIFT_Y,
      REG_SHIFT_Z,
      REG_VIEW_DIST
   } vrtp_reg_type;

   // Sideband that travels alongside the divider
   typedef struct packed {
      logic                      neg_x;
      logic                      neg_y;
      logic                      ovf_x;
      logic                      ovf_y;
      logic                      visible;
      logic signed [FIELD_W-1:0] depth;
   } vrtp_side_type;

   typedef struct packed {
      logic [N_W-1:0] num_x;
      logic [N_W-1:0] num_y;
      logic [D_W-1:0] den;
      vrtp_side_type  side;
   } vrtp_div_in_type;

   typedef struct packed {
      logic [D_W-1:0]   rem_x;
      logic [D_W-1:0]   rem_y;
      logic [QUO_W-1:0] low_x;
      logic [QUO_W-1:0] low_y;
      logic [QUO_W-1:0] quo_x;
      logic [QUO_W-1:0] quo_y;
      logic [D_W-1:0]   den;
      vrtp_side_type    side;
   } vrtp_div_stage_type;

   typedef struct packed {
      logic [QUO_W-1:0] quo_x;
      logic [QUO_W-1:0] quo_y;
      vrtp_side_type    side;
   } vrtp_div_out_type;

   // (a +/- b) / 2^14 rounded half up
   function automatic logic signed [COORD_W-1:0] rot_sum(
      input logic signed [PROD_W-1:0] a,
      input logic signed [PROD_W-1:0] b,
      input logic                     sub
   );
      logic signed [PROD_W:0] ea;
      logic signed [PROD_W:0] eb;
      logic signed [PROD_W:0] sum;
      ea = (PROD_W+1)'(a);
      eb = (PROD_W+1)'(b);
      if (sub) begin
         sum = ea - eb + (PROD_W+1)'(ROT_ROUND);
      end else begin
         sum = ea + eb + (PROD_W+1)'(ROT_ROUND);
      end
      return COORD_W'(sum >>> TRIG_FRAC);
   endfunction

   // Clamp to the port range
   function automatic logic signed [FIELD_W-1:0] sat_field(
      input logic signed [COORD_W-1:0] v
   );
      logic signed [COORD_W-1:0] hi;
      logic signed [COORD_W-1:0] lo;
      hi = COORD_W'(FIELD_MAX);
      lo = COORD_W'(FIELD_MIN);
      if (v > hi) begin
         return FIELD_MAX;
      end else if (v < lo) begin
         return FIELD_MIN;
      end else begin
         return FIELD_W'(v);
      end
   endfunction

   // Signed quotient plus screen centre, saturated
   function automatic logic signed [FIELD_W-1:0] screen_pos(
      input logic [QUO_W-1:0] quo,
      input logic             neg,
      input logic             ovf,
      input int               center
   );
      logic signed [COORD_W-1:0] r;
      logic signed [COORD_W-1:0] sum;
      r = COORD_W'($signed({1'b0, quo}));
      if (!neg) begin
         r = -r;
      end
      sum = r + COORD_W'(center << FRACTION_BITS);
      if (ovf) begin
         return neg ? FIELD_MAX : FIELD_MIN;
      end else begin
         return sat_field(sum);
      end
   endfunction

endpackage

[rtl/core/vrtp_sine.sv]
// ----------------------------------------------------------------------------
// vrtp_sine
// Pipelined Q14 sine of an angle, quarter-wave odd polynomial in Q16.
// ----------------------------------------------------------------------------
module vrtp_sine (
   input  logic                                  clock,
   input  logic [vrtp_pkg::ANGLE_BITS-1:0]       angle,
   output logic signed [vrtp_pkg::TRIG_W-1:0]    sine
);

   logic [1:0]                              quad;
   logic [vrtp_pkg::ANGLE_BITS-3:0]         phase;
   logic [vrtp_pkg::PHASE_W-1:0]            z_in;

   logic [vrtp_pkg::PHASE_W-1:0]            z1_ff, z2_ff, z3_ff;
   logic                                    neg1_ff, neg2_ff, neg3_ff, neg4_ff;
   logic [2*vrtp_pkg::PHASE_W-1:0]          zz1_ff;
   logic [vrtp_pkg::PHASE_W-1:0]            zsq_in, zsq2_ff;
   logic [2*vrtp_pkg::PHASE_W-1:0]          z2c2_ff;
   logic [vrtp_pkg::PHASE_W-1:0]            t_in;
   logic [2*vrtp_pkg::PHASE_W-1:0]          z2t3_ff;
   logic [vrtp_pkg::PHASE_W-1:0]            u_in;
   logic [2*vrtp_pkg::PHASE_W-1:0]          zu4_ff;
   logic [vrtp_pkg::PHASE_W-1:0]            s_in;
   logic [vrtp_pkg::PHASE_W-1:0]            res_in;
   logic signed [vrtp_pkg::TRIG_W-1:0]      mag_in;
   logic signed [vrtp_pkg::TRIG_W-1:0]      sine_in;
   logic signed [vrtp_pkg::TRIG_W-1:0]      sine_ff;

   // quadrant fold to a Q16 phase in [0, 1]
   always_comb begin
      quad  = angle[vrtp_pkg::ANGLE_BITS-1 -: 2];
      phase = angle[vrtp_pkg::ANGLE_BITS-3:0];
      z_in  = vrtp_pkg::PHASE_W'(phase) << (18 - vrtp_pkg::ANGLE_BITS);
      if (quad[0]) begin
         z_in = vrtp_pkg::PHASE_W'(vrtp_pkg::PHASE_ONE) - z_in;
      end
   end

   // polynomial terms, at most one product per stage
   always_comb begin
      zsq_in  = vrtp_pkg::PHASE_W'(zz1_ff >> 16);
      t_in    = vrtp_pkg::PHASE_W'(vrtp_pkg::POLY_B) - vrtp_pkg::PHASE_W'(z2c2_ff >> 16);
      u_in    = vrtp_pkg::PHASE_W'(vrtp_pkg::POLY_A) - vrtp_pkg::PHASE_W'(z2t3_ff >> 16);
      s_in    = vrtp_pkg::PHASE_W'(zu4_ff >> 16);
      res_in  = (s_in + vrtp_pkg::PHASE_W'(2)) >> 2;
      mag_in  = vrtp_pkg::TRIG_W'(res_in);
      sine_in = neg4_ff ? -mag_in : mag_in;
   end

   always_ff @(posedge clock) begin
      z1_ff   <= z_in;
      neg1_ff <= quad[1];
      zz1_ff  <= z_in * z_in;

      z2_ff   <= z1_ff;
      neg2_ff <= neg1_ff;
      zsq2_ff <= zsq_in;
      z2c2_ff <= zsq_in * vrtp_pkg::PHASE_W'(vrtp_pkg::POLY_C);

      z3_ff   <= z2_ff;
      neg3_ff <= neg2_ff;
      z2t3_ff <= zsq2_ff * t_in;

      neg4_ff <= neg3_ff;
      zu4_ff  <= z3_ff * u_in;

      sine_ff <= sine_in;
   end

   assign sine = sine_ff;

endmodule

[rtl/core/vrtp_divider.sv]
// ----------------------------------------------------------------------------
// vrtp_divider
// Two-lane restoring divider, one quotient bit per stage, with sideband.
// ----------------------------------------------------------------------------
module vrtp_divider (
   input  logic                         clock,
   input  logic                         en,
   input  vrtp_pkg::vrtp_div_in_type    div_in,
   output vrtp_pkg::vrtp_div_out_type   div_out
);

   vrtp_pkg::vrtp_div_stage_type init_stg;
   vrtp_pkg::vrtp_div_stage_type stg_in [vrtp_pkg::QUO_W];
   vrtp_pkg::vrtp_div_stage_type stg_ff [vrtp_pkg::QUO_W];

   // one quotient bit for both lanes
   function automatic vrtp_pkg::vrtp_div_stage_type div_step(
      input vrtp_pkg::vrtp_div_stage_type s
   );
      logic [vrtp_pkg::D_W:0]       sh_x;
      logic [vrtp_pkg::D_W:0]       sh_y;
      logic [vrtp_pkg::D_W:0]       dd;
      vrtp_pkg::vrtp_div_stage_type n;
      n    = s;
      dd   = {1'b0, s.den};
      sh_x = {s.rem_x, s.low_x[vrtp_pkg::QUO_W-1]};
      sh_y = {s.rem_y, s.low_y[vrtp_pkg::QUO_W-1]};
      n.low_x = s.low_x << 1;
      n.low_y = s.low_y << 1;
      if (sh_x >= dd) begin
         n.rem_x = vrtp_pkg::D_W'(sh_x - dd);
         n.quo_x = {s.quo_x[vrtp_pkg::QUO_W-2:0], 1'b1};
      end else begin
         n.rem_x = vrtp_pkg::D_W'(sh_x);
         n.quo_x = {s.quo_x[vrtp_pkg::QUO_W-2:0], 1'b0};
      end
      if (sh_y >= dd) begin
         n.rem_y = vrtp_pkg::D_W'(sh_y - dd);
         n.quo_y = {s.quo_y[vrtp_pkg::QUO_W-2:0], 1'b1};
      end else begin
         n.rem_y = vrtp_pkg::D_W'(sh_y);
         n.quo_y = {s.quo_y[vrtp_pkg::QUO_W-2:0], 1'b0};
      end
      return n;
   endfunction

   // top dividend bits seed the partial remainder
   always_comb begin
      init_stg.rem_x = vrtp_pkg::D_W'(div_in.num_x >> vrtp_pkg::QUO_W);
      init_stg.rem_y = vrtp_pkg::D_W'(div_in.num_y >> vrtp_pkg::QUO_W);
      init_stg.low_x = div_in.num_x[vrtp_pkg::QUO_W-1:0];
      init_stg.low_y = div_in.num_y[vrtp_pkg::QUO_W-1:0];
      init_stg.quo_x = '0;
      init_stg.quo_y = '0;
      init_stg.den   = div_in.den;
      init_stg.side  = div_in.side;
   end

   for (genvar k = 0; k < vrtp_pkg::QUO_W; k++) begin : g_stage
      if (k == 0) begin : g_first
         assign stg_in[k] = div_step(init_stg);
      end else begin : g_next
         assign stg_in[k] = div_step(stg_ff[k-1]);
      end

      always_ff @(posedge clock) begin
         if (en) begin
            stg_ff[k] <= stg_in[k];
         end
      end
   end

   assign div_out.quo_x = stg_ff[vrtp_pkg::QUO_W-1].quo_x;
   assign div_out.quo_y = stg_ff[vrtp_pkg::QUO_W-1].quo_y;
   assign div_out.side  = stg_ff[vrtp_pkg::QUO_W-1].side;

endmodule

[rtl/core/vertex_rotate_translate_project_unit.sv]
// ----------------------------------------------------------------------------
// vertex_rotate_translate_project_unit
// Euler rotation (X, Y, Z), translation and perspective projection of points.
// ----------------------------------------------------------------------------
// One vertex can be taken per clock while the input is not stalled, and its
// result passes through the rotation, translation and scaling stages, the
// one-bit-per-stage divider and one output register; the whole pipeline holds
// while the result port is stalled, and an empty first stage still takes a
// transaction then. Sine and cosine of the three angles come from a 5-stage
// polynomial pipeline fed by the angle registers, so after reset and after
// any register write the input is stalled while it refills.
// Register writes are always taken and belong in idle periods.
// ----------------------------------------------------------------------------
module vertex_rotate_translate_project_unit (
   input  logic                                  clock,
   input  logic                                  reset,

   input  logic                                  req_valid,
   output logic                                  req_stall,
   input  logic signed [vrtp_pkg::FIELD_W-1:0]   req_in_x,
   input  logic signed [vrtp_pkg::FIELD_W-1:0]   req_in_y,
   input  logic signed [vrtp_pkg::FIELD_W-1:0]   req_in_z,

   output logic                                  rsp_valid,
   input  logic                                  rsp_stall,
   output logic signed [vrtp_pkg::FIELD_W-1:0]   rsp_screen_x,
   output logic signed [vrtp_pkg::FIELD_W-1:0]   rsp_screen_y,
   output logic signed [vrtp_pkg::FIELD_W-1:0]   rsp_depth,
   output logic                                  rsp_visible,

   input  logic                                  csr_valid,
   output logic                                  csr_ready,
   input  logic [2:0]                            csr_index,
   input  logic [vrtp_pkg::FIELD_W-1:0]          csr_data
);

   // ---------------- configuration ----------------
   logic [vrtp_pkg::ANGLE_W-1:0]          angle_x_ff, angle_y_ff, angle_z_ff;
   logic signed [vrtp_pkg::FIELD_W-1:0]   shift_x_ff, shift_y_ff, shift_z_ff;
   logic [vrtp_pkg::DIST_W-1:0]           dist_ff;
   logic [vrtp_pkg::SETTLE_W-1:0]         settle_ff;
   logic                                  csr_write;
   logic                                  settle_busy;

   assign csr_ready   = 1'b1;
   assign csr_write   = csr_valid && csr_ready;
   assign settle_busy = (settle_ff != '0);

   always_ff @(posedge clock) begin
      if (reset) begin
         angle_x_ff <= '0;
         angle_y_ff <= '0;
         angle_z_ff <= '0;
         shift_x_ff <= '0;
         shift_y_ff <= '0;
         shift_z_ff <= '0;
         dist_ff    <= vrtp_pkg::DIST_W'(300);
      end else if (csr_write) begin
         case (vrtp_pkg::vrtp_reg_type'(csr_index))
            vrtp_pkg::REG_ANGLE_X:   angle_x_ff <= csr_data[vrtp_pkg::ANGLE_W-1:0];
            vrtp_pkg::REG_ANGLE_Y:   angle_y_ff <= csr_data[vrtp_pkg::ANGLE_W-1:0];
            vrtp_pkg::REG_ANGLE_Z:   angle_z_ff <= csr_data[vrtp_pkg::ANGLE_W-1:0];
            vrtp_pkg::REG_SHIFT_X:   shift_x_ff <= csr_data;
            vrtp_pkg::REG_SHIFT_Y:   shift_y_ff <= csr_data;
            vrtp_pkg::REG_SHIFT_Z:   shift_z_ff <= csr_data;
            vrtp_pkg::REG_VIEW_DIST: dist_ff    <= csr_data[vrtp_pkg::DIST_W-1:0];
            default: ;
         endcase
      end
   end

   // trig pipeline refill counter
   always_ff @(posedge clock) begin
      if (reset || csr_write) begin
         settle_ff <= vrtp_pkg::SETTLE_W'(vrtp_pkg::SINE_LATENCY);
      end else if (settle_busy) begin
         settle_ff <= settle_ff - 1'b1;
      end
   end

   // ---------------- sine / cosine ----------------
   logic signed [vrtp_pkg::TRIG_W-1:0] sin_x, cos_x, sin_y, cos_y, sin_z, cos_z;

   vrtp_sine u_sin_x (.clock(clock), .angle(angle_x_ff[vrtp_pkg::ANGLE_BITS-1:0]),
                      .sine(sin_x));
   vrtp_sine u_cos_x (.clock(clock),
                      .angle(angle_x_ff[vrtp_pkg::ANGLE_BITS-1:0] + vrtp_pkg::QUARTER_TURN),
                      .sine(cos_x));
   vrtp_sine u_sin_y (.clock(clock), .angle(angle_y_ff[vrtp_pkg::ANGLE_BITS-1:0]),
                      .sine(sin_y));
   vrtp_sine u_cos_y (.clock(clock),
                      .angle(angle_y_ff[vrtp_pkg::ANGLE_BITS-1:0] + vrtp_pkg::QUARTER_TURN),
                      .sine(cos_y));
   vrtp_sine u_sin_z (.clock(clock), .angle(angle_z_ff[vrtp_pkg::ANGLE_BITS-1:0]),
                      .sine(sin_z));
   vrtp_sine u_cos_z (.clock(clock),
                      .angle(angle_z_ff[vrtp_pkg::ANGLE_BITS-1:0] + vrtp_pkg::QUARTER_TURN),
                      .sine(cos_z));

   // ---------------- pipeline control ----------------
   logic                              en;
   logic                              ld1;
   logic                              req_accept;
   logic [vrtp_pkg::PIPE_DEPTH-1:0]   vld_ff;
   logic                              rsp_valid_ff;

   assign en         = !rsp_valid_ff || !rsp_stall;
   assign ld1        = en || !vld_ff[0];
   assign req_stall  = settle_busy || !ld1;
   assign req_accept = req_valid && !req_stall;

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (ld1) begin
            vld_ff[0] <= req_accept;
         end
         if (en) begin
            vld_ff[vrtp_pkg::PIPE_DEPTH-1:1] <= vld_ff[vrtp_pkg::PIPE_DEPTH-2:0];
            rsp_valid_ff <= vld_ff[vrtp_pkg::PIPE_DEPTH-1];
         end
      end
   end

   // ---------------- rotation about X ----------------
   logic signed [vrtp_pkg::COORD_W-1:0] x_s1_ff;
   logic signed [vrtp_pkg::PROD_W-1:0]  yc_s1_ff, zs_s1_ff, ys_s1_ff, zc_s1_ff;

   always_ff @(posedge clock) begin
      if (ld1) begin
         x_s1_ff  <= vrtp_pkg::COORD_W'(req_in_x);
         yc_s1_ff <= req_in_y * cos_x;
         zs_s1_ff <= req_in_z * sin_x;
         ys_s1_ff <= req_in_y * sin_x;
         zc_s1_ff <= req_in_z * cos_x;
      end
   end

   logic signed [vrtp_pkg::COORD_W-1:0] x_s2_ff, y_s2_ff, z_s2_ff;

   always_ff @(posedge clock) begin
      if (en) begin
         x_s2_ff <= x_s1_ff;
         y_s2_ff <= vrtp_pkg::rot_sum(yc_s1_ff, zs_s1_ff, 1'b1);
         z_s2_ff <= vrtp_pkg::rot_sum(ys_s1_ff, zc_s1_ff, 1'b0);
      end
   end

   // ---------------- rotation about Y ----------------
   logic signed [vrtp_pkg::COORD_W-1:0] y_s3_ff;
   logic signed [vrtp_pkg::PROD_W-1:0]  xc_s3_ff, zs_s3_ff, xs_s3_ff, zc_s3_ff;

   always_ff @(posedge clock) begin
      if (en) begin
         y_s3_ff  <= y_s2_ff;
         xc_s3_ff <= x_s2_ff * cos_y;
         zs_s3_ff <= z_s2_ff * sin_y;
         xs_s3_ff <= x_s2_ff * sin_y;
         zc_s3_ff <= z_s2_ff * cos_y;
      end
   end

   logic signed [vrtp_pkg::COORD_W-1:0] x_s4_ff, y_s4_ff, z_s4_ff;

   always_ff @(posedge clock) begin
      if (en) begin
         y_s4_ff <= y_s3_ff;
         x_s4_ff <= vrtp_pkg::rot_sum(xc_s3_ff, zs_s3_ff, 1'b1);
         z_s4_ff <= vrtp_pkg::rot_sum(xs_s3_ff, zc_s3_ff, 1'b0);
      end
   end

   // ---------------- rotation about Z ----------------
   logic signed [vrtp_pkg::COORD_W-1:0] z_s5_ff;
   logic signed [vrtp_pkg::PROD_W-1:0]  xc_s5_ff, ys_s5_ff, xs_s5_ff, yc_s5_ff;

   always_ff @(posedge clock) begin
      if (en) begin
         z_s5_ff  <= z_s4_ff;
         xc_s5_ff <= x_s4_ff * cos_z;
         ys_s5_ff <= y_s4_ff * sin_z;
         xs_s5_ff <= x_s4_ff * sin_z;
         yc_s5_ff <= y_s4_ff * cos_z;
      end
   end

   logic signed [vrtp_pkg::COORD_W-1:0] x_s6_ff, y_s6_ff, z_s6_ff;

   always_ff @(posedge clock) begin
      if (en) begin
         z_s6_ff <= z_s5_ff;
         x_s6_ff <= vrtp_pkg::rot_sum(xc_s5_ff, ys_s5_ff, 1'b1);
         y_s6_ff <= vrtp_pkg::rot_sum(xs_s5_ff, yc_s5_ff, 1'b0);
      end
   end

   // ---------------- translation ----------------
   logic signed [vrtp_pkg::COORD_W-1:0] x_s7_ff, y_s7_ff, z_s7_ff;

   always_ff @(posedge clock) begin
      if (en) begin
         x_s7_ff <= x_s6_ff + vrtp_pkg::COORD_W'(shift_x_ff);
         y_s7_ff <= y_s6_ff + vrtp_pkg::COORD_W'(shift_y_ff);
         z_s7_ff <= z_s6_ff + vrtp_pkg::COORD_W'(shift_z_ff);
      end
   end

   // ---------------- scale by view distance ----------------
   logic signed [vrtp_pkg::NUM_W-1:0]   num_x_s8_ff, num_y_s8_ff;
   logic signed [vrtp_pkg::COORD_W-1:0] z_s8_ff;
   logic signed [vrtp_pkg::DIST_W:0]    dist_s;

   assign dist_s = $signed({1'b0, dist_ff});

   always_ff @(posedge clock) begin
      if (en) begin
         num_x_s8_ff <= x_s7_ff * dist_s;
         num_y_s8_ff <= y_s7_ff * dist_s;
         z_s8_ff     <= z_s7_ff;
      end
   end

   // ---------------- dividend / divisor set-up ----------------
   // quotient = floor((2|num|*2^F + |z|) / 2|z|), rounded half away from zero
   logic [vrtp_pkg::NUM_W-1:0]     mag_x, mag_y;
   logic [vrtp_pkg::COORD_W-1:0]   zmag;
   logic [vrtp_pkg::N_W-1:0]       nx_s9_ff, ny_s9_ff;
   logic [vrtp_pkg::D_W-1:0]       den_s9_ff;
   vrtp_pkg::vrtp_side_type        side_in, side_s9_ff;

   always_comb begin
      mag_x = num_x_s8_ff[vrtp_pkg::NUM_W-1] ? -num_x_s8_ff : num_x_s8_ff;
      mag_y = num_y_s8_ff[vrtp_pkg::NUM_W-1] ? -num_y_s8_ff : num_y_s8_ff;
      zmag  = -z_s8_ff;
      side_in.neg_x   = num_x_s8_ff[vrtp_pkg::NUM_W-1];
      side_in.neg_y   = num_y_s8_ff[vrtp_pkg::NUM_W-1];
      side_in.ovf_x   = 1'b0;
      side_in.ovf_y   = 1'b0;
      side_in.visible = z_s8_ff[vrtp_pkg::COORD_W-1];
      side_in.depth   = vrtp_pkg::sat_field(z_s8_ff);
   end

   always_ff @(posedge clock) begin
      if (en) begin
         nx_s9_ff   <= (vrtp_pkg::N_W'(mag_x) << (vrtp_pkg::FRACTION_BITS + 1))
                       + vrtp_pkg::N_W'(zmag);
         ny_s9_ff   <= (vrtp_pkg::N_W'(mag_y) << (vrtp_pkg::FRACTION_BITS + 1))
                       + vrtp_pkg::N_W'(zmag);
         den_s9_ff  <= {zmag, 1'b0};
         side_s9_ff <= side_in;
      end
   end

   // ---------------- quotient range check ----------------
   vrtp_pkg::vrtp_div_in_type div_in_ff, div_in_in;
   vrtp_pkg::vrtp_div_out_type div_out;

   always_comb begin
      div_in_in.num_x = nx_s9_ff;
      div_in_in.num_y = ny_s9_ff;
      div_in_in.den   = den_s9_ff;
      div_in_in.side  = side_s9_ff;
      div_in_in.side.ovf_x = (nx_s9_ff >> vrtp_pkg::QUO_W) >= vrtp_pkg::N_W'(den_s9_ff);
      div_in_in.side.ovf_y = (ny_s9_ff >> vrtp_pkg::QUO_W) >= vrtp_pkg::N_W'(den_s9_ff);
   end

   always_ff @(posedge clock) begin
      if (en) begin
         div_in_ff <= div_in_in;
      end
   end

   vrtp_divider u_divider (
      .clock   (clock),
      .en      (en),
      .div_in  (div_in_ff),
      .div_out (div_out)
   );

   // ---------------- output register ----------------
   logic signed [vrtp_pkg::FIELD_W-1:0] rsp_screen_x_ff, rsp_screen_y_ff, rsp_depth_ff;
   logic                                rsp_visible_ff;

   always_ff @(posedge clock) begin
      if (en) begin
         rsp_visible_ff <= div_out.side.visible;
         if (div_out.side.visible) begin
            rsp_screen_x_ff <= vrtp_pkg::screen_pos(div_out.quo_x, div_out.side.neg_x,
                                                    div_out.side.ovf_x, vrtp_pkg::CENTER_X);
            rsp_screen_y_ff <= vrtp_pkg::screen_pos(div_out.quo_y, div_out.side.neg_y,
                                                    div_out.side.ovf_y, vrtp_pkg::CENTER_Y);
            rsp_depth_ff    <= div_out.side.depth;
         end else begin
            rsp_screen_x_ff <= '0;
            rsp_screen_y_ff <= '0;
            rsp_depth_ff    <= '0;
         end
      end
   end

   assign rsp_valid    = rsp_valid_ff;
   assign rsp_screen_x = rsp_screen_x_ff;
   assign rsp_screen_y = rsp_screen_y_ff;
   assign rsp_depth    = rsp_depth_ff;
   assign rsp_visible  = rsp_visible_ff;

   // ---------------- assertions ----------------
   // no vertex may enter on stale trig values after a register write
   a_write_blocks_input: assert property (@(posedge clock) disable iff (reset)
      csr_write |=> !req_accept)
      else $error("vertex accepted right after a register write");

   // hidden points report zeros
   a_hidden_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_visible |->
         rsp_screen_x == '0 && rsp_screen_y == '0 && rsp_depth == '0)
      else $error("non-visible result with non-zero fields");

   // a visible point always has negative depth
   a_visible_depth: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_visible |-> rsp_depth[vrtp_pkg::FIELD_W-1])
      else $error("visible result with non-negative depth");

   // a held first stage keeps its vertex
   a_first_held: assert property (@(posedge clock) disable iff (reset)
      vld_ff[0] && !ld1 |=> vld_ff[0])
      else $error("first stage dropped a vertex while held");

endmodule
